// ----- hdl/hrt_pkg.sv -----
// Shared types and constants for the hashed route table.
`default_nettype none

package hrt_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int WAYS_DEF    = 4;
    localparam int NODE_W      = 8;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS
    } t_state;

    typedef struct packed {
        t_opcode             opcode;
        logic [NODE_W-1:0]   dest_node;
        logic [NODE_W-1:0]   next_node;
    } t_req;

    typedef struct packed {
        t_status                status;
        logic [NODE_W-1:0]      next_hop;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_rsp;

    // Outcome of one bucket update, handed from the way matcher to the top.
    typedef struct packed {
        t_status           status;
        logic [NODE_W-1:0] hop;
        logic              inc;
        logic              dec;
    } t_upd;

endpackage

`default_nettype wire

// ----- hdl/hrt_way_match.sv -----
// Compares all ways of one bucket row and builds the updated row.
`default_nettype none

module hrt_way_match
    import hrt_pkg::*;
#(
    parameter int WAYS = WAYS_DEF
) (
    input  var t_req                      i_req,
    input  var logic [WAYS*(1+2*NODE_W)-1:0] i_row,
    output var logic [WAYS*(1+2*NODE_W)-1:0] o_row,
    output var t_upd                      o_upd
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    // Row layout: valid bits low, then the destinations, then the next hops.
    logic [WAYS-1:0]             valid_old;
    logic [WAYS-1:0][NODE_W-1:0] dest_old;
    logic [WAYS-1:0][NODE_W-1:0] hop_old;
    logic [WAYS-1:0]             valid_new;
    logic [WAYS-1:0][NODE_W-1:0] dest_new;
    logic [WAYS-1:0][NODE_W-1:0] hop_new;
    logic                        hit;
    logic [WAY_W-1:0]            hit_way;
    logic                        free;
    logic [WAY_W-1:0]            free_way;

    assign {hop_old, dest_old, valid_old} = i_row;
    assign o_row = {hop_new, dest_new, valid_new};

    // First matching way and first free way, lowest index wins.
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && valid_old[w] && (dest_old[w] == i_req.dest_node)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!free && !valid_old[w]) begin
                free     = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        valid_new    = valid_old;
        dest_new     = dest_old;
        hop_new      = hop_old;
        o_upd.status = ST_NOT_FOUND;
        o_upd.hop    = '0;
        o_upd.inc    = 1'b0;
        o_upd.dec    = 1'b0;
        unique case (i_req.opcode)
            OP_SET: begin
                if (hit) begin
                    hop_new[hit_way] = i_req.next_node;
                    o_upd.status     = ST_OK;
                end else if (free) begin
                    valid_new[free_way] = 1'b1;
                    dest_new[free_way]  = i_req.dest_node;
                    hop_new[free_way]   = i_req.next_node;
                    o_upd.inc           = 1'b1;
                    o_upd.status        = ST_OK;
                end else begin
                    o_upd.status = ST_FULL;
                end
            end
            OP_REMOVE: begin
                if (hit) begin
                    valid_new[hit_way] = 1'b0;
                    o_upd.dec          = 1'b1;
                    o_upd.status       = ST_OK;
                end
            end
            OP_LOOKUP: begin
                if (hit) begin
                    o_upd.hop    = hop_old[hit_way];
                    o_upd.status = ST_OK;
                end
            end
            default: begin
                o_upd.status = ST_NOT_FOUND;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/hashed_route_table_unit.sv -----
// Top level of the hashed route table: bucket memory, control and result register.
// The request and its bucket row are registered when the input beat is taken, and the result
// is registered when the access commits; no new request is taken before that write-back.
// A stalled result holds the request in its access cycle until the result register frees.
// Reset clears control state, then a clearing pass empties every bucket row;
// no input beat is taken during that pass.
`default_nettype none

module hashed_route_table_unit
    import hrt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int WAYS  = WAYS_DEF
) (
    input  var logic i_clk,
    input  var logic i_rst_n,
    input  var logic i_in_valid,
    output var logic o_in_stall,
    input  var t_req i_in_data,
    output var logic o_out_valid,
    input  var logic i_out_stall,
    output var t_rsp o_out_data
);

    localparam int ENTRIES  = SLOTS * WAYS;
    localparam int ROW_BITS = WAYS * (1 + 2 * NODE_W);
    localparam int ROW_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int KEYS     = 2 ** NODE_W;

    logic [ROW_BITS-1:0] r_mem [SLOTS];
    logic [ROW_W-1:0]    bucket_lut [KEYS];

    t_state              r_state;
    t_state              n_state;
    logic [ROW_W-1:0]    r_clr_idx;
    t_req                r_req;
    logic [ROW_W-1:0]    r_row_idx;
    logic [ROW_BITS-1:0] r_rd_row;
    logic [ROW_BITS-1:0] new_row;
    t_upd                upd;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    t_rsp                r_out_data;
    logic                in_accept;
    logic                commit;
    logic                clr_last;

    // Bucket of every possible key, worked out at elaboration.
    for (genvar g = 0; g < KEYS; g++) begin : g_lut
        assign bucket_lut[g] = ROW_W'(g % SLOTS);
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign commit    = (r_state == S_ACCESS) && (!r_out_valid || !i_out_stall);
    assign clr_last  = (r_clr_idx == ROW_W'(SLOTS - 1));

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + ROW_W'(1);
            end
        end
    end

    // Bucket memory: one write port for clearing and write-back, one registered read.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem[r_clr_idx] <= '0;
        end else if (commit) begin
            r_mem[r_row_idx] <= new_row;
        end
        if (in_accept) begin
            r_rd_row <= r_mem[bucket_lut[i_in_data.dest_node]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req     <= i_in_data;
            r_row_idx <= bucket_lut[i_in_data.dest_node];
        end
    end

    hrt_way_match #(
        .WAYS (WAYS)
    ) u_match (
        .i_req (r_req),
        .i_row (r_rd_row),
        .o_row (new_row),
        .o_upd (upd)
    );

    always_comb begin
        n_count = r_count;
        if (upd.inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (upd.dec && (r_count != '0)) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data.status      <= upd.status;
            r_out_data.next_hop    <= upd.hop;
            r_out_data.entry_count <= COUNT_OUT_W'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("live entry count exceeds table size");

    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (upd.status == ST_FULL)) |=> (r_count == $past(r_count)))
        else $error("set into a full bucket changed the entry count");

    a_accept_to_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_ACCESS))
        else $error("accepted request did not enter the access cycle");

    a_miss_no_hop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK)) |-> (o_out_data.next_hop == '0))
        else $error("failed request carries a nonzero next hop");

endmodule

`default_nettype wire

// ----- sim/route_table_shadow.sv -----
// Scoreboard class: a shadow copy of the route table and the queue of expected responses.
package route_table_shadow_pkg;
    import hrt_pkg::*;

    localparam int SHADOW_SLOTS   = SLOTS_DEF;
    localparam int SHADOW_WAYS    = WAYS_DEF;
    localparam int SHADOW_ENTRIES = SLOTS_DEF * WAYS_DEF;

    class route_table_shadow;
        bit                  way_used [SHADOW_ENTRIES];
        logic [NODE_W-1:0]   way_key  [SHADOW_ENTRIES];
        logic [NODE_W-1:0]   way_hop  [SHADOW_ENTRIES];
        int unsigned         live;
        t_rsp                pending_rsp [$];
        int unsigned         errors;

        function new();
            for (int i = 0; i < SHADOW_ENTRIES; i++) begin
                way_used[i] = 1'b0;
                way_key[i]  = '0;
                way_hop[i]  = '0;
            end
            live   = 0;
            errors = 0;
        endfunction

        // Applies one accepted request beat to the shadow table and queues its response.
        function void note_request(t_req req);
            int   base;
            int   hit;
            int   w;
            bit   placed;
            t_rsp rsp;
            base = (int'(req.dest_node) % SHADOW_SLOTS) * SHADOW_WAYS;
            hit  = -1;
            for (w = 0; w < SHADOW_WAYS; w++) begin
                if (hit < 0 && way_used[base + w] && way_key[base + w] == req.dest_node)
                    hit = base + w;
            end
            rsp.status   = ST_NOT_FOUND;
            rsp.next_hop = '0;
            case (req.opcode)
                OP_SET: begin
                    if (hit >= 0) begin
                        way_hop[hit] = req.next_node;
                        rsp.status   = ST_OK;
                    end else begin
                        // The lowest free way takes a new destination.
                        rsp.status = ST_FULL;
                        placed     = 1'b0;
                        for (w = 0; w < SHADOW_WAYS; w++) begin
                            if (!placed && !way_used[base + w]) begin
                                way_used[base + w] = 1'b1;
                                way_key[base + w]  = req.dest_node;
                                way_hop[base + w]  = req.next_node;
                                live++;
                                placed     = 1'b1;
                                rsp.status = ST_OK;
                            end
                        end
                    end
                end
                OP_REMOVE: begin
                    if (hit >= 0) begin
                        way_used[hit] = 1'b0;
                        if (live > 0)
                            live--;
                        rsp.status = ST_OK;
                    end
                end
                OP_LOOKUP: begin
                    if (hit >= 0) begin
                        rsp.next_hop = way_hop[hit];
                        rsp.status   = ST_OK;
                    end
                end
                default: begin
                end
            endcase
            rsp.entry_count = COUNT_OUT_W'(live);
            pending_rsp.push_back(rsp);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (pending_rsp.size() == 0) begin
                errors++;
                $display("%0t: unexpected response beat: expected none, got status %0d hop %0d count %0d",
                         $time, got.status, got.next_hop, got.entry_count);
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, want.status, got.status);
            end
            if (got.next_hop !== want.next_hop) begin
                errors++;
                $display("%0t: next_hop mismatch: expected %0d, got %0d",
                         $time, want.next_hop, got.next_hop);
            end
            if (got.entry_count !== want.entry_count) begin
                errors++;
                $display("%0t: entry_count mismatch: expected %0d, got %0d",
                         $time, want.entry_count, got.entry_count);
            end
        endfunction

        function int outstanding();
            return pending_rsp.size();
        endfunction
    endclass

endpackage

// ----- sim/hashed_route_table_unit_tb.sv -----
// Testbench for hashed_route_table_unit: directed and random requests checked against a shadow table.
module hashed_route_table_unit_tb
    import hrt_pkg::*, route_table_shadow_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 1000000;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_req i_in_data   = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_rsp o_out_data;

    route_table_shadow rtable;
    bit                calm         = 1'b0;
    bit                hold_off_req = 1'b0;
    logic [NODE_W-1:0] recent_keys [$];
    int unsigned       cycles       = 0;

    hashed_route_table_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            rtable.note_request(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall)
            rtable.check_result(o_out_data);
    end

    // Mostly back to back, sometimes a few cycles, rarely a long pause.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [1:0] pick_opcode(int set_pct, int rem_pct, int look_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < set_pct)
            return OP_SET;
        if (roll < set_pct + rem_pct)
            return OP_REMOVE;
        if (roll < set_pct + rem_pct + look_pct)
            return OP_LOOKUP;
        return OP_UNUSED;
    endfunction

    // Mode 0 spreads keys over all nodes, mode 1 crowds two buckets, mode 2 reuses recent keys.
    function automatic logic [NODE_W-1:0] pick_dest(int mode);
        int bucket;
        if (mode == 1) begin
            bucket = $urandom_range(0, 1) ? 3 : 12;
            return NODE_W'(bucket + 16 * $urandom_range(0, 15));
        end
        if (mode == 2 && recent_keys.size() > 0 && $urandom_range(0, 9) < 7)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        return NODE_W'($urandom_range(0, 255));
    endfunction

    task automatic drive_request(logic [1:0] op, logic [NODE_W-1:0] dest,
                                 logic [NODE_W-1:0] nxt);
        t_req req;
        req.opcode    = t_opcode'(op);
        req.dest_node = dest;
        req.next_node = nxt;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic idle_input(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (rtable.outstanding() != 0);
    endtask

    task automatic send_gapped(logic [1:0] op, logic [NODE_W-1:0] dest,
                               logic [NODE_W-1:0] nxt);
        drive_request(op, dest, nxt);
        idle_input(pick_gap());
    endtask

    task automatic run_phase(int count, int set_pct, int rem_pct, int look_pct,
                             int dest_mode, int quiet_items, int hold_at);
        int                i;
        logic [1:0]        op;
        logic [NODE_W-1:0] dest;
        for (i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_off_req = 1'b1;
            calm = (i < quiet_items) || (hold_at >= 0 && i >= hold_at && i < hold_at + 40);
            op   = pick_opcode(set_pct, rem_pct, look_pct);
            dest = pick_dest(dest_mode);
            if (op == OP_SET) begin
                recent_keys.push_back(dest);
                if (recent_keys.size() > 32)
                    void'(recent_keys.pop_front());
            end
            send_gapped(op, dest, NODE_W'($urandom_range(0, 255)));
        end
        calm = 1'b0;
    endtask

    // Response side: random stalls, plus one long hold-off when the sender asks for it.
    initial begin : out_side
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                n = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                n = pick_gap();
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    initial begin
        rtable = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, unused opcode, then bucket zero filled past its ways.
        send_gapped(OP_LOOKUP, 8'd0,   8'd0);
        send_gapped(OP_REMOVE, 8'd255, 8'd0);
        send_gapped(OP_UNUSED, 8'hAA,  8'h55);
        send_gapped(OP_SET,    8'd0,   8'd255);
        send_gapped(OP_SET,    8'd16,  8'd0);
        send_gapped(OP_SET,    8'd32,  8'hAA);
        send_gapped(OP_SET,    8'd48,  8'h55);
        send_gapped(OP_SET,    8'd64,  8'd1);
        send_gapped(OP_SET,    8'd16,  8'h3C);
        send_gapped(OP_LOOKUP, 8'd16,  8'd0);
        send_gapped(OP_LOOKUP, 8'd48,  8'hFF);
        send_gapped(OP_LOOKUP, 8'd64,  8'd0);
        send_gapped(OP_REMOVE, 8'd32,  8'd0);
        // The freed middle way is the lowest free one now.
        send_gapped(OP_SET,    8'd64,  8'h81);
        send_gapped(OP_LOOKUP, 8'd64,  8'd0);
        send_gapped(OP_REMOVE, 8'd32,  8'd0);
        send_gapped(OP_SET,    8'd255, 8'd255);
        send_gapped(OP_LOOKUP, 8'd255, 8'd0);
        send_gapped(OP_UNUSED, 8'd255, 8'd255);
        send_gapped(OP_REMOVE, 8'd0,   8'd255);
        send_gapped(OP_LOOKUP, 8'd0,   8'd0);
        pause_until_drained();

        // Fill most of the table, then crowd two buckets with a long response hold-off.
        run_phase(400, 70, 10, 18, 0, 0, -1);
        pause_until_drained();
        run_phase(400, 40, 30, 28, 1, 0, 50);
        pause_until_drained();
        run_phase(350, 15, 60, 23, 2, 0, -1);
        pause_until_drained();
        run_phase(600, 35, 30, 33, 2, 150, -1);

        pause_until_drained();
        repeat (10) @(posedge i_clk);
        if (rtable.errors == 0 && rtable.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
